// ----- rtl/rse_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rse_pkg
// Shared types and constants for the Reed-Solomon encoder: configuration
// register map, reset values and the control bundle driven into the cells.
// ----------------------------------------------------------------------------
package rse_pkg;

  // Configuration register widths
  localparam int POLY_W  = 9;
  localparam int CNT_W   = 6;
  localparam int CFG_W   = 9;
  localparam int CFG_A_W = 1;

  // Configuration register map
  localparam logic [CFG_A_W-1:0] REG_PRIMITIVE_POLY = 1'b0;
  localparam logic [CFG_A_W-1:0] REG_PARITY_COUNT   = 1'b1;

  // Configuration reset values
  localparam logic [POLY_W-1:0] POLY_RESET  = 9'd285;
  localparam logic [CNT_W-1:0]  COUNT_RESET = 6'd16;

  // Per-cycle command broadcast to every cell of the chain
  typedef struct packed {
    logic clear;       // zero coefficient and remainder
    logic build_step;  // multiply generator by (x + root)
    logic data_step;   // divide one message symbol
    logic drain_step;  // shift remainder one place toward the output
  } rse_ctl_t;

endpackage
`default_nettype wire

// ----- rtl/reed_solomon_encoder_core.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// reed_solomon_encoder_core
// Systematic Reed-Solomon encoder over GF(2^SYMBOL_BITS) built as a chain of
// MAX_PARITY identical cells, with a configurable field polynomial.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries message symbols, highest
//   coefficient first; in_msg_last marks the final one. Output channel
//   (out_valid/out_ready) returns each symbol unchanged, then after the last
//   symbol the n parity symbols, highest first; out_word_last marks the end.
//   Configuration: cfg_we with cfg_addr 0 writes primitive_poly, 1 writes
//   parity_count (saturated to MAX_PARITY). Write only while idle.
// Timing and throughput:
//   A symbol shows on the output in the cycle after its transaction. Within a
//   message one symbol is taken per cycle unless the output stalls; every cell
//   updates in the same cycle through its own GF multiplier. After the last
//   symbol the input stalls while the remainder shifts out through the chain.
// Reset and configuration:
//   After reset or a configuration write the chain rebuilds the generator,
//   one root per cycle, so the input is held off until the build ends; the
//   remainder is cleared. A stalled receiver holds the output register and
//   the input stalls with it; nothing is dropped.
// ----------------------------------------------------------------------------
module reed_solomon_encoder_core
  import rse_pkg::*;
#(
  parameter int SYMBOL_BITS = 8,
  parameter int MAX_PARITY  = 32
) (
  input  wire                    clk,
  input  wire                    rst_n,
  // configuration
  input  wire                    cfg_we,
  input  wire [CFG_A_W-1:0]      cfg_addr,
  input  wire [CFG_W-1:0]        cfg_wdata,
  // input channel
  input  wire                    in_valid,
  output logic                   in_ready,
  input  wire [SYMBOL_BITS-1:0]  in_data_symbol,
  input  wire                    in_msg_last,
  // result channel
  output logic                   out_valid,
  input  wire                    out_ready,
  output logic [SYMBOL_BITS-1:0] out_code_symbol,
  output logic                   out_is_parity,
  output logic                   out_word_last
);

  localparam logic [CNT_W-1:0] MAX_CNT   = CNT_W'(MAX_PARITY);
  localparam logic [CNT_W-1:0] RESET_EFF = (COUNT_RESET > MAX_CNT) ? MAX_CNT : COUNT_RESET;
  localparam logic [SYMBOL_BITS-1:0] ONE = SYMBOL_BITS'(1);

  typedef enum logic [2:0] {
    ST_BUILD = 3'b001,
    ST_RUN   = 3'b010,
    ST_DRAIN = 3'b100
  } state_t;

  state_t                  state_r, state_nxt;
  logic [POLY_W-1:0]       poly_r, poly_nxt;
  logic [CNT_W-1:0]        count_r, count_nxt;
  logic [CNT_W-1:0]        n_eff, n_eff_nxt;
  logic [CNT_W-1:0]        rem_r, rem_nxt;
  logic [SYMBOL_BITS-1:0]  root_r, root_nxt;
  logic [SYMBOL_BITS+POLY_W-1:0] poly_ext;
  logic [SYMBOL_BITS-1:0]  red;
  logic [SYMBOL_BITS-1:0]  fb;
  logic [SYMBOL_BITS-1:0]  mul_a;
  logic                    cfg_hit;
  logic                    in_acc;
  logic                    out_load;
  rse_ctl_t                ctl;

  logic                    out_valid_r, out_valid_nxt;
  logic [SYMBOL_BITS-1:0]  out_code_r, out_code_nxt;
  logic                    out_is_parity_r, out_is_parity_nxt;
  logic                    out_word_last_r, out_word_last_nxt;

  logic [SYMBOL_BITS-1:0]  coef_w [MAX_PARITY];
  logic [SYMBOL_BITS-1:0]  par_w  [MAX_PARITY];

  // Field reduction term: low bits of the polynomial, x^m implied
  assign poly_ext = {{SYMBOL_BITS{1'b0}}, poly_r};
  assign red      = poly_ext[SYMBOL_BITS-1:0];

  assign n_eff    = (count_r > MAX_CNT) ? MAX_CNT : count_r;
  assign out_load = !out_valid_r || out_ready;
  assign in_ready = (state_r == ST_RUN) && out_load;
  assign in_acc   = in_valid && in_ready;
  assign cfg_hit  = cfg_we && ((cfg_addr == REG_PRIMITIVE_POLY) ||
                               (cfg_addr == REG_PARITY_COUNT));
  assign fb       = in_data_symbol ^ par_w[0];
  assign mul_a    = (state_r == ST_BUILD) ? root_r : fb;

  // Take configuration writes
  always_comb begin
    poly_nxt  = poly_r;
    count_nxt = count_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        REG_PRIMITIVE_POLY: poly_nxt  = cfg_wdata[POLY_W-1:0];
        REG_PARITY_COUNT:   count_nxt = cfg_wdata[CNT_W-1:0];
        default: ;
      endcase
    end
    n_eff_nxt = (count_nxt > MAX_CNT) ? MAX_CNT : count_nxt;
  end

  // Sequence generator build, message division and remainder drain
  always_comb begin
    state_nxt = state_r;
    rem_nxt   = rem_r;
    root_nxt  = root_r;
    ctl       = '0;
    if (cfg_hit) begin
      state_nxt = ST_BUILD;
      rem_nxt   = n_eff_nxt;
      root_nxt  = ONE;
      ctl.clear = 1'b1;
    end else begin
      unique case (state_r)
        ST_BUILD: begin
          if (rem_r == '0) begin
            state_nxt = ST_RUN;
          end else begin
            ctl.build_step = 1'b1;
            rem_nxt        = rem_r - CNT_W'(1);
            if (root_r[SYMBOL_BITS-1]) begin
              root_nxt = {root_r[SYMBOL_BITS-2:0], 1'b0} ^ red;
            end else begin
              root_nxt = {root_r[SYMBOL_BITS-2:0], 1'b0};
            end
          end
        end
        ST_RUN: begin
          if (in_acc) begin
            ctl.data_step = 1'b1;
            if (in_msg_last && (n_eff != '0)) begin
              state_nxt = ST_DRAIN;
              rem_nxt   = n_eff;
            end
          end
        end
        ST_DRAIN: begin
          if (out_load) begin
            ctl.drain_step = 1'b1;
            rem_nxt        = rem_r - CNT_W'(1);
            if (rem_r == CNT_W'(1)) begin
              state_nxt = ST_RUN;
            end
          end
        end
        default: begin
          state_nxt = ST_BUILD;
          rem_nxt   = n_eff;
          root_nxt  = ONE;
          ctl.clear = 1'b1;
        end
      endcase
    end
  end

  // Load the output register with a data or a parity symbol
  always_comb begin
    out_valid_nxt     = out_valid_r;
    out_code_nxt      = out_code_r;
    out_is_parity_nxt = out_is_parity_r;
    out_word_last_nxt = out_word_last_r;
    if (out_load) begin
      if (in_acc) begin
        out_valid_nxt     = 1'b1;
        out_code_nxt      = in_data_symbol;
        out_is_parity_nxt = 1'b0;
        out_word_last_nxt = in_msg_last && (n_eff == '0);
      end else if (state_r == ST_DRAIN) begin
        out_valid_nxt     = 1'b1;
        out_code_nxt      = par_w[0];
        out_is_parity_nxt = 1'b1;
        out_word_last_nxt = (rem_r == CNT_W'(1));
      end else begin
        out_valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_BUILD;
      poly_r      <= POLY_RESET;
      count_r     <= COUNT_RESET;
      rem_r       <= RESET_EFF;
      root_r      <= ONE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      poly_r      <= poly_nxt;
      count_r     <= count_nxt;
      rem_r       <= rem_nxt;
      root_r      <= root_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload holds without reset
  always_ff @(posedge clk) begin
    out_code_r      <= out_code_nxt;
    out_is_parity_r <= out_is_parity_nxt;
    out_word_last_r <= out_word_last_nxt;
  end

  // Chain of cells: coefficients pass downward, remainder moves toward cell 0
  for (genvar j = 0; j < MAX_PARITY; j++) begin : g_cell
    logic [SYMBOL_BITS-1:0] coef_prev;
    logic [SYMBOL_BITS-1:0] par_next;

    if (j == 0) begin : g_first
      assign coef_prev = ONE;
    end else begin : g_mid
      assign coef_prev = coef_w[j-1];
    end

    if (j == MAX_PARITY - 1) begin : g_end
      assign par_next = '0;
    end else begin : g_link
      assign par_next = par_w[j+1];
    end

    rse_cell #(
      .SYMBOL_BITS(SYMBOL_BITS)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (ctl),
      .red         (red),
      .mul_a       (mul_a),
      .coef_prev_i (coef_prev),
      .par_next_i  (par_next),
      .coef_o      (coef_w[j]),
      .par_o       (par_w[j])
    );
  end

  assign out_valid       = out_valid_r;
  assign out_code_symbol = out_code_r;
  assign out_is_parity   = out_is_parity_r;
  assign out_word_last   = out_word_last_r;

  // A drain always has parity symbols left to send
  a_drain_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DRAIN) |-> (rem_r != '0))
    else $error("drain state with no parity left");

  // A last symbol with parity enabled starts the drain
  a_last_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_msg_last && (n_eff != '0) && !cfg_hit)
      |=> (state_r == ST_DRAIN))
    else $error("last symbol did not start parity drain");

  // The final parity symbol closes the codeword
  a_final_parity: assert property (@(posedge clk) disable iff (!rst_n)
    ((state_r == ST_DRAIN) && out_load && (rem_r == CNT_W'(1)))
      |=> (out_valid_r && out_is_parity_r && out_word_last_r))
    else $error("final parity symbol without word_last");

endmodule
`default_nettype wire

// ----- rtl/rse_cell.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rse_cell
// One tap of the encoder chain: holds one generator coefficient and one
// remainder symbol, with a single GF multiplier shared between building the
// generator and dividing the message.
// ----------------------------------------------------------------------------
module rse_cell
  import rse_pkg::*;
#(
  parameter int SYMBOL_BITS = 8
) (
  input  wire                    clk,
  input  wire                    rst_n,
  input  rse_ctl_t               ctl,
  input  wire [SYMBOL_BITS-1:0]  red,          // reduction polynomial, low bits
  input  wire [SYMBOL_BITS-1:0]  mul_a,        // root while building, feedback else
  input  wire [SYMBOL_BITS-1:0]  coef_prev_i,  // coefficient of the higher neighbor
  input  wire [SYMBOL_BITS-1:0]  par_next_i,   // remainder of the lower neighbor
  output logic [SYMBOL_BITS-1:0] coef_o,
  output logic [SYMBOL_BITS-1:0] par_o
);

  // Shift-and-reduce multiply modulo the field polynomial
  function automatic logic [SYMBOL_BITS-1:0] gf_mul(
    input logic [SYMBOL_BITS-1:0] a,
    input logic [SYMBOL_BITS-1:0] b,
    input logic [SYMBOL_BITS-1:0] p
  );
    logic [SYMBOL_BITS-1:0] r;
    logic [SYMBOL_BITS-1:0] x;
    r = '0;
    x = a;
    for (int i = 0; i < SYMBOL_BITS; i++) begin
      if (b[i]) begin
        r = r ^ x;
      end
      if (x[SYMBOL_BITS-1]) begin
        x = {x[SYMBOL_BITS-2:0], 1'b0} ^ p;
      end else begin
        x = {x[SYMBOL_BITS-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  logic [SYMBOL_BITS-1:0] coef_r, coef_nxt;
  logic [SYMBOL_BITS-1:0] par_r, par_nxt;
  logic [SYMBOL_BITS-1:0] mul_b;
  logic [SYMBOL_BITS-1:0] prod;

  // Share the multiplier between generator build and division
  assign mul_b = ctl.build_step ? coef_prev_i : coef_r;
  assign prod  = gf_mul(mul_a, mul_b, red);

  // Select next coefficient and remainder
  always_comb begin
    coef_nxt = coef_r;
    par_nxt  = par_r;
    if (ctl.clear) begin
      coef_nxt = '0;
      par_nxt  = '0;
    end else if (ctl.build_step) begin
      coef_nxt = coef_r ^ prod;
    end else if (ctl.data_step) begin
      par_nxt = par_next_i ^ prod;
    end else if (ctl.drain_step) begin
      par_nxt = par_next_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coef_r <= '0;
      par_r  <= '0;
    end else begin
      coef_r <= coef_nxt;
      par_r  <= par_nxt;
    end
  end

  assign coef_o = coef_r;
  assign par_o  = par_r;

endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the systematic Reed-Solomon encoder. Messages go in
// on the valid/ready input channel. A bit-accurate GF(2^8) encoder in the
// bench predicts the pass-through symbols and the parity symbols, and every
// code symbol is checked against it. The run sweeps field polynomials and
// parity counts, including zero, saturated counts and writes mid-message,
// with random gaps on both channels and two long output hold-offs.
// ----------------------------------------------------------------------------
module tb
  import rse_pkg::*;
();

  localparam int SYM_W       = 8;
  localparam int MAX_PAR     = 32;
  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int HOLD_CYCLES = 300;
  localparam int PRINT_LIMIT = 30;
  localparam int PHASES      = 10;
  localparam int PHASE_SYMS  = 40;

  typedef struct packed {
    logic [SYM_W-1:0] data;
    logic             last;
  } msg_sym_t;

  typedef struct packed {
    logic [SYM_W-1:0] sym;
    logic             parity;
    logic             last;
  } code_sym_t;

  // DUT connections
  logic               clk             = 1'b0;
  logic               rst_n           = 1'b0;
  logic               cfg_we          = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr        = '0;
  logic [CFG_W-1:0]   cfg_wdata       = '0;
  logic               in_valid        = 1'b0;
  logic               in_ready;
  logic [SYM_W-1:0]   in_data_symbol  = '0;
  logic               in_msg_last     = 1'b0;
  logic               out_valid;
  logic               out_ready       = 1'b0;
  logic [SYM_W-1:0]   out_code_symbol;
  logic               out_is_parity;
  logic               out_word_last;

  // Encoder model state
  logic [POLY_W-1:0]  field_poly;
  logic [CNT_W-1:0]   parity_cfg;
  logic [SYM_W-1:0]   gen_coef [MAX_PAR];
  logic [SYM_W-1:0]   rem_reg  [MAX_PAR];

  msg_sym_t  msg_sym_q[$];
  code_sym_t code_exp_q[$];

  // Handshake bookkeeping and pacing controls
  bit          in_taken      = 1'b0;
  bit          out_taken     = 1'b0;
  bit          in_gaps_on    = 1'b1;
  bit          out_gaps_on   = 1'b1;
  int          in_gap_left   = 0;
  int          out_stall_left = 0;
  int          hold_left     = 0;
  int          hold_requests = 0;
  int          hold_served   = 0;
  int unsigned cycle_count   = 0;
  int          err_count     = 0;
  int          syms_sent     = 0;
  int          msgs_sent     = 0;
  int          code_checked  = 0;
  int          reg_writes    = 0;

  reed_solomon_encoder_core #(
    .SYMBOL_BITS (SYM_W),
    .MAX_PARITY  (MAX_PAR)
  ) dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_symbol  (in_data_symbol),
    .in_msg_last     (in_msg_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_code_symbol (out_code_symbol),
    .out_is_parity   (out_is_parity),
    .out_word_last   (out_word_last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // GF(2^8) encoder model
  // --------------------------------------------------------------------------

  // Shift-and-reduce multiply; the x^8 term of the polynomial is implied
  function automatic logic [SYM_W-1:0] gf_mult(input logic [SYM_W-1:0] a_in,
                                               input logic [SYM_W-1:0] b_in);
    logic [SYM_W-1:0] a;
    logic [SYM_W-1:0] b;
    logic [SYM_W-1:0] prod;
    logic             carry;
    a    = a_in;
    b    = b_in;
    prod = '0;
    for (int i = 0; i < SYM_W; i++) begin
      if (b[0]) prod ^= a;
      b     = b >> 1;
      carry = a[SYM_W-1];
      a     = a << 1;
      if (carry) a ^= field_poly[SYM_W-1:0];
    end
    return prod;
  endfunction

  // Saturate the configured count at the chain length
  function automatic int parity_len();
    return (parity_cfg > MAX_PAR) ? MAX_PAR : int'(parity_cfg);
  endfunction

  function automatic void clear_remainder();
    for (int i = 0; i < MAX_PAR; i++) rem_reg[i] = '0;
  endfunction

  // Expand prod (x + alpha^i); keep the non-leading coefficients, highest first
  function automatic void rebuild_generator();
    logic [SYM_W-1:0] g [0:MAX_PAR];
    logic [SYM_W-1:0] root;
    int               n;
    n = parity_len();
    for (int i = 0; i <= MAX_PAR; i++) g[i] = '0;
    g[0] = SYM_W'(1);
    root = SYM_W'(1);
    for (int i = 0; i < n; i++) begin
      g[i + 1] = gf_mult(root, g[i]);
      for (int k = i; k >= 1; k--) g[k] ^= gf_mult(root, g[k - 1]);
      root = gf_mult(root, SYM_W'(2));
    end
    for (int i = 0; i < MAX_PAR; i++) gen_coef[i] = (i < n) ? g[i + 1] : '0;
  endfunction

  // Divide one symbol into the remainder; on the last symbol, emit the parity
  function automatic void encode_symbol(input msg_sym_t item);
    logic [SYM_W-1:0] fb;
    int               n;
    code_sym_t        res;
    n = parity_len();
    if (n > 0) begin
      fb = item.data ^ rem_reg[0];
      for (int j = 0; j + 1 < n; j++) rem_reg[j] = rem_reg[j + 1] ^ gf_mult(fb, gen_coef[j]);
      rem_reg[n - 1] = gf_mult(fb, gen_coef[n - 1]);
    end
    res = '{sym: item.data, parity: 1'b0, last: item.last && (n == 0)};
    code_exp_q = {code_exp_q, res};
    if (item.last) begin
      for (int j = 0; j < n; j++) begin
        res = '{sym: rem_reg[j], parity: 1'b1, last: (j + 1 == n)};
        code_exp_q = {code_exp_q, res};
      end
      clear_remainder();
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (err_count < PRINT_LIMIT)
      $display("ERROR cycle %0d: %s: expected %0h, got %0h", cycle_count, what, want, got);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Input driver: one transaction per queued symbol, random gap after each
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    msg_sym_t next_sym;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (in_gap_left > 0) begin
        in_gap_left--;
        in_valid <= 1'b0;
      end else if (msg_sym_q.size() > 0) begin
        next_sym = msg_sym_q.pop_front();
        in_data_symbol <= next_sym.data;
        in_msg_last    <= next_sym.last;
        in_valid       <= 1'b1;
        in_gap_left = in_gaps_on ? $urandom_range(0, 6) : 0;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output receiver: random stall per result, long hold-off on request
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    logic rdy;
    rdy = 1'b1;
    if (hold_left > 0) begin
      hold_left--;
      rdy = 1'b0;
    end else if (hold_served != hold_requests && out_valid) begin
      hold_served++;
      hold_left = HOLD_CYCLES - 1;
      rdy = 1'b0;
    end else begin
      if (out_taken) out_stall_left = out_gaps_on ? $urandom_range(0, 6) : 0;
      if (out_stall_left > 0) begin
        out_stall_left--;
        rdy = 1'b0;
      end
    end
    out_ready <= rdy;
  end

  // --------------------------------------------------------------------------
  // Monitor: check each result transaction, predict from each input one
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    code_sym_t got;
    code_sym_t want;
    in_taken  = 1'b0;
    out_taken = 1'b0;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        out_taken = 1'b1;
        got = {out_code_symbol, out_is_parity, out_word_last};
        if (code_exp_q.size() == 0) begin
          report_mismatch("code symbol with nothing expected", '0, 32'(got));
        end else begin
          want = code_exp_q.pop_front();
          code_checked++;
          if (got.sym !== want.sym)
            report_mismatch("code_symbol", 32'(want.sym), 32'(got.sym));
          if (got.parity !== want.parity)
            report_mismatch("is_parity", 32'(want.parity), 32'(got.parity));
          if (got.last !== want.last)
            report_mismatch("word_last", 32'(want.last), 32'(got.last));
        end
      end
      if (in_valid && in_ready) begin
        in_taken = 1'b1;
        syms_sent++;
        if (in_msg_last) msgs_sent++;
        encode_symbol('{data: in_data_symbol, last: in_msg_last});
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d code symbols outstanding",
               cycle_count, code_exp_q.size());
      $display("status: fail");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------

  // Wait until nothing is in flight and the encoder takes input again
  task automatic wait_idle();
    while (msg_sym_q.size() > 0 || in_valid || code_exp_q.size() > 0 || !in_ready)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_A_W-1:0] addr, input logic [CFG_W-1:0] value);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    if (addr == REG_PRIMITIVE_POLY) field_poly = value[POLY_W-1:0];
    else parity_cfg = value[CNT_W-1:0];
    clear_remainder();
    rebuild_generator();
    reg_writes++;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_sym(input logic [SYM_W-1:0] data, input logic last);
    msg_sym_t item;
    item = '{data: data, last: last};
    msg_sym_q = {msg_sym_q, item};
  endtask

  // Random message; an unterminated one leaves the remainder half built
  task automatic queue_message(input int len, input bit terminate);
    logic [SYM_W-1:0] data;
    for (int i = 0; i < len; i++) begin
      case ($urandom_range(0, 15))
        0:       data = '0;
        1:       data = '1;
        default: data = SYM_W'($urandom_range(0, 255));
      endcase
      queue_sym(data, terminate && (i == len - 1));
    end
  endtask

  initial begin
    int queued;
    int len;
    int pick;
    logic [CFG_W-1:0] poly_val;
    logic [CFG_W-1:0] count_val;

    // Model comes out of reset with the register defaults
    field_poly = POLY_RESET;
    parity_cfg = COUNT_RESET;
    clear_remainder();
    rebuild_generator();

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: symbol extremes at reset settings
    queue_sym(8'hFF, 1'b0);
    queue_sym(8'h00, 1'b1);
    queue_sym(8'h00, 1'b1);
    queue_sym(8'hFF, 1'b1);

    // Non-primitive polynomial, single parity symbol
    write_reg(REG_PRIMITIVE_POLY, 9'd257);
    write_reg(REG_PARITY_COUNT, 9'd1);
    queue_sym(8'hA5, 1'b0);
    queue_sym(8'h5A, 1'b1);

    // No parity at all: the data symbol closes the codeword
    write_reg(REG_PARITY_COUNT, 9'd0);
    queue_sym(8'h12, 1'b0);
    queue_sym(8'h34, 1'b1);
    queue_sym(8'hFF, 1'b1);

    // Count beyond the chain length saturates; top polynomial
    write_reg(REG_PRIMITIVE_POLY, 9'd511);
    write_reg(REG_PARITY_COUNT, 9'd63);
    queue_sym(8'h01, 1'b0);
    queue_sym(8'h80, 1'b1);

    // Full chain with the standard field
    write_reg(REG_PRIMITIVE_POLY, 9'd285);
    write_reg(REG_PARITY_COUNT, 9'd32);
    queue_message(3, 1'b1);
    queue_sym(8'h00, 1'b1);

    // Register write in the middle of a message restarts the division
    queue_sym(8'h77, 1'b0);
    queue_sym(8'h88, 1'b0);
    write_reg(REG_PARITY_COUNT, 9'd5);
    queue_sym(8'h99, 1'b1);

    // Random phases, each under a fresh setting
    for (int phase = 0; phase < PHASES; phase++) begin
      pick = $urandom_range(0, 7);
      case (pick)
        0:       poly_val = 9'd257;
        1:       poly_val = 9'd511;
        2:       poly_val = 9'd285;
        default: poly_val = CFG_W'($urandom_range(257, 511));
      endcase
      pick = $urandom_range(0, 9);
      case (pick)
        0:       count_val = 9'd0;
        1:       count_val = CFG_W'($urandom_range(33, 63));
        default: count_val = CFG_W'($urandom_range(1, 32));
      endcase
      pick = $urandom_range(0, 2);
      if (pick != 1) write_reg(REG_PRIMITIVE_POLY, poly_val);
      if (pick != 0) write_reg(REG_PARITY_COUNT, count_val);

      // First phase runs back to back; the rest mostly with gaps
      in_gaps_on  = (phase != 0) && ($urandom_range(0, 3) != 0);
      out_gaps_on = (phase != 0) && ($urandom_range(0, 3) != 0);
      if (phase == 4 || phase == 8) hold_requests++;

      queued = 0;
      while (queued < PHASE_SYMS) begin
        pick = $urandom_range(0, 9);
        if (pick < 5) len = $urandom_range(1, 4);
        else if (pick < 9) len = $urandom_range(5, 16);
        else len = $urandom_range(17, 48);
        queue_message(len, 1'b1);
        queued += len;
      end
      // Leave a message open so the next write has to discard it
      if (phase % 3 == 2) queue_message($urandom_range(1, 5), 1'b0);
    end

    // Drain: all symbols sent, then every expected code symbol or a bound
    while (msg_sym_q.size() > 0 || in_valid) @(negedge clk);
    for (int w = 0; w < 20000 && code_exp_q.size() > 0; w++) @(negedge clk);
    repeat (2 * MAX_PAR) @(negedge clk);
    if (code_exp_q.size() > 0)
      report_mismatch("code symbols never produced", 0, code_exp_q.size());

    $display("Run covered %0d message symbols in %0d messages and %0d checked code symbols",
             syms_sent, msgs_sent, code_checked);
    $display("over %0d register writes, %0d long output hold-offs, %0d mismatches",
             reg_writes, hold_served, err_count);
    if (err_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ----- files.f -----
rtl/rse_pkg.sv
rtl/rse_cell.sv
rtl/reed_solomon_encoder_core.sv
tb/tb.sv
